// File: hw/rtl/jls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_pkg: shared types for the josephus ring
// Sequencer states and the control group driven into the cell chain.
// ----------------------------------------------------------------------------
package jls_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_FIND,
		ST_DONE
	} jls_state_t;

	typedef struct packed {
		logic load;   // initialize every cell from the job
		logic shift;  // rotate the ring by one position
		logic kill;   // head cell leaves the ring on this rotation
	} jls_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/jls_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_cell: one ring position
// Holds an alive flag and a person number and takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module jls_cell
	import jls_pkg::*;
#(
	parameter int ID_W = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jls_ctrl_t       ctrl,
	input  wire logic            load_alive,
	input  wire logic [ID_W-1:0] load_id,
	input  wire logic            nxt_alive,
	input  wire logic [ID_W-1:0] nxt_id,
	output logic                 alive_q,
	output logic [ID_W-1:0]      id_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b1;
		end else if (ctrl.load) begin
			alive_q <= load_alive;
		end else if (ctrl.shift) begin
			alive_q <= nxt_alive;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			id_q <= load_id;
		end else if (ctrl.shift) begin
			id_q <= nxt_id;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/jls_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_chain: ring of cells
// Cell 0 is the head; on shift each cell takes the next one's contents and
// the last cell takes the head, with its alive flag cleared on a kill.
// ----------------------------------------------------------------------------
module jls_chain
	import jls_pkg::*;
#(
	parameter int NUM  = 128,
	parameter int ID_W = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jls_ctrl_t       ctrl,
	input  wire logic [7:0]      people_n,
	output logic                 head_alive,
	output logic [ID_W-1:0]      head_id
);

	localparam int CMP_W = ((ID_W > 8) ? ID_W : 8) + 1;

	logic [NUM-1:0]  alive;
	logic [ID_W-1:0] id [NUM];

	for (genvar i = 0; i < NUM; i++) begin : g_cell
		logic            nxt_alive;
		logic [ID_W-1:0] nxt_id;
		logic            ld_alive;

		if (i == NUM - 1) begin : g_tail
			assign nxt_alive = alive[0] & ~ctrl.kill;
			assign nxt_id    = id[0];
		end else begin : g_mid
			assign nxt_alive = alive[i+1];
			assign nxt_id    = id[i+1];
		end

		assign ld_alive = (CMP_W'(i) < CMP_W'(people_n));

		jls_cell #(
			.ID_W(ID_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.load_alive(ld_alive),
			.load_id   (ID_W'(i + 1)),
			.nxt_alive (nxt_alive),
			.nxt_id    (nxt_id),
			.alive_q   (alive[i]),
			.id_q      (id[i])
		);
	end

	assign head_alive = alive[0];
	assign head_id    = id[0];

endmodule
`default_nettype wire

// File: hw/rtl/josephus_last_survivor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// josephus_last_survivor: last survivor of a counting-out ring
// A chain of MAX_PEOPLE cells rotates one ring position per cycle past the
// head cell, where live people are counted and every step-th one removed.
// ----------------------------------------------------------------------------
// sequence: accept, load, a visit to each ring position in turn over full
//   rotations of MAX_PEOPLE cells (about step*(n-1) live visits plus dead
//   positions), leaving the run, the rotation to the survivor and its
//   capture, then the output register; a rejected job goes straight to it.
// throughput: one job at a time, set by the single-position rotation per cycle
// reset: all cells alive, sequencer idle, no result pending
module josephus_last_survivor
	import jls_pkg::*;
#(
	parameter int MAX_PEOPLE = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] people_count,
	input  wire logic [7:0] step,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      survivor,
	output logic            input_error
);

	localparam int ID_W  = $clog2(MAX_PEOPLE + 1);
	localparam int CMP_W = ((ID_W > 8) ? ID_W : 8) + 1;

	jls_state_t      state_q, state_d;
	jls_ctrl_t       ctrl;
	logic [7:0]      n_q;
	logic [7:0]      m_q;
	logic [7:0]      cnt_q;
	logic [ID_W-1:0] removed_q;
	logic            err_q;
	logic [ID_W-1:0] surv_q;
	logic            out_valid_q;
	logic [7:0]      survivor_q;
	logic            input_error_q;
	logic            head_alive;
	logic [ID_W-1:0] head_id;
	logic            in_acc;
	logic            bad_job;
	logic            ring_done;
	logic            hit;
	logic            out_free;

	assign in_acc    = in_valid && !in_stall;
	assign bad_job   = (people_count == 8'd0) || (step == 8'd0) ||
		(CMP_W'(people_count) > CMP_W'(MAX_PEOPLE));
	assign ring_done = (CMP_W'(removed_q) + CMP_W'(1)) >= CMP_W'(n_q);
	assign hit       = (9'(cnt_q) + 9'd1) == 9'(m_q);
	assign out_free  = !out_valid_q || !out_stall;

	jls_chain #(
		.NUM (MAX_PEOPLE),
		.ID_W(ID_W)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.people_n  (n_q),
		.head_alive(head_alive),
		.head_id   (head_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctrl       = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = bad_job ? ST_DONE : ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctrl.load = 1'b1;
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				if (ring_done) begin
					state_d = ST_FIND;
				end else begin
					ctrl.shift = 1'b1;
					ctrl.kill  = head_alive && hit;
				end
			end
			ST_FIND: begin
				// only one cell is still alive: rotate until it reaches the head
				if (head_alive) begin
					state_d = ST_DONE;
				end else begin
					ctrl.shift = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			removed_q <= '0;
		end else if (ctrl.load) begin
			cnt_q     <= '0;
			removed_q <= '0;
		end else if (ctrl.shift && state_q == ST_RUN && head_alive) begin
			if (hit) begin
				cnt_q     <= '0;
				removed_q <= removed_q + ID_W'(1);
			end else begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q   <= people_count;
			m_q   <= step;
			err_q <= bad_job;
		end
		if (state_q == ST_FIND && head_alive) begin
			surv_q <= head_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			survivor_q    <= err_q ? 8'd0 : 8'(surv_q);
			input_error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign survivor    = survivor_q;
	assign input_error = input_error_q;

endmodule
`default_nettype wire

// File: hw/rtl/jls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_checker: port-level checks for the josephus ring
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module jls_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] people_count,
	input wire logic [7:0] step,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] survivor,
	input wire logic       input_error
);

	// a job owns the block once its beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a job is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(survivor) && $stable(input_error)))
		else $error("stalled result beat changed");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && input_error) |-> (survivor == 8'd0))
		else $error("rejected job with nonzero survivor");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !input_error) |-> (survivor != 8'd0))
		else $error("accepted job returned survivor zero");

endmodule

bind josephus_last_survivor jls_checker u_jls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.people_count(people_count),
	.step        (step),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.survivor    (survivor),
	.input_error (input_error)
);
`default_nettype wire

// File: tb/sv/josephus_last_survivor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// josephus_last_survivor_test: self-checking bench for the ring survivor block
// Feeds a table of edge-case jobs and then random jobs with random idle on
// both channels, predicts every survivor in the bench and checks each beat.
// ----------------------------------------------------------------------------
module josephus_last_survivor_test;
	import jls_pkg::*;

	localparam int MAX_PEOPLE     = 128;
	localparam int RANDOM_JOBS    = 80;
	localparam int QUIET_TAIL     = 15;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int REPORT_LIMIT   = 10;
	localparam int DIR_ROWS       = 20;

	typedef struct packed {
		logic [7:0] survivor;
		logic       input_error;
	} survivor_beat_t;

	typedef struct packed {
		logic [7:0] people;
		logic [7:0] stride;
		logic       typed;
		logic [7:0] typed_survivor;
		logic       typed_error;
	} ring_job_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] people_count = 8'd0;
	logic [7:0] step = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] survivor;
	logic       input_error;

	josephus_last_survivor #(
		.MAX_PEOPLE(MAX_PEOPLE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.people_count(people_count),
		.step(step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.survivor(survivor),
		.input_error(input_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// edge-case jobs; typed rows carry an answer that is obvious by inspection
	ring_job_t dir_table [0:DIR_ROWS-1] = '{
		'{8'd1,   8'd1,   1'b1, 8'd1,   1'b0},  // single person right after reset
		'{8'd1,   8'd255, 1'b1, 8'd1,   1'b0},
		'{8'd128, 8'd1,   1'b1, 8'd128, 1'b0},  // unit step, full ring
		'{8'd7,   8'd1,   1'b1, 8'd7,   1'b0},
		'{8'd0,   8'd5,   1'b1, 8'd0,   1'b1},  // empty ring
		'{8'd129, 8'd3,   1'b1, 8'd0,   1'b1},  // one past capacity
		'{8'd255, 8'd255, 1'b1, 8'd0,   1'b1},
		'{8'd10,  8'd0,   1'b1, 8'd0,   1'b1},  // zero step
		'{8'd0,   8'd0,   1'b1, 8'd0,   1'b1},
		'{8'd2,   8'd2,   1'b0, 8'd0,   1'b0},
		'{8'd7,   8'd3,   1'b0, 8'd0,   1'b0},
		'{8'd41,  8'd3,   1'b0, 8'd0,   1'b0},
		'{8'd2,   8'd255, 1'b0, 8'd0,   1'b0},  // step wraps the ring many times
		'{8'd5,   8'd200, 1'b0, 8'd0,   1'b0},
		'{8'd3,   8'd170, 1'b0, 8'd0,   1'b0},
		'{8'd128, 8'd2,   1'b0, 8'd0,   1'b0},
		'{8'd85,  8'd85,  1'b0, 8'd0,   1'b0},
		'{8'd128, 8'd255, 1'b0, 8'd0,   1'b0},  // slowest job
		'{8'd130, 8'd7,   1'b1, 8'd0,   1'b1},  // rejected, ring left as it was
		'{8'd6,   8'd2,   1'b0, 8'd0,   1'b0}
	};

	// bench copy of the ring state
	bit          ring_alive [0:MAX_PEOPLE-1];
	int unsigned ring_pos;
	int unsigned ring_counted;
	int unsigned ring_removed;

	ring_job_t      job_q [$];
	survivor_beat_t survivor_q [$];
	int unsigned    mismatch_count = 0;
	int unsigned    idle_cycles = 0;
	bit             idle_on = 1'b1;
	bit             timed_out = 1'b0;

	function automatic survivor_beat_t predict_survivor(logic [7:0] people, logic [7:0] stride);
		survivor_beat_t beat;
		int unsigned    n;
		int unsigned    m;
		n = people;
		m = stride;
		beat.survivor = 8'd0;
		beat.input_error = 1'b1;
		if (n == 0 || n > MAX_PEOPLE || m == 0)
			return beat;
		for (int i = 0; i < MAX_PEOPLE; i++)
			ring_alive[i] = (i < n);
		ring_pos = 0;
		ring_counted = 0;
		ring_removed = 0;
		while (ring_removed + 1 < n) begin
			if (ring_alive[ring_pos]) begin
				ring_counted++;
				if (ring_counted == m) begin
					ring_alive[ring_pos] = 1'b0;
					ring_removed++;
					ring_counted = 0;
				end
			end
			ring_pos = (ring_pos + 1 >= n) ? 0 : ring_pos + 1;
		end
		beat.input_error = 1'b0;
		for (int i = n - 1; i >= 0; i--)
			if (ring_alive[i])
				beat.survivor = 8'(i + 1);
		return beat;
	endfunction

	function automatic ring_job_t random_job();
		ring_job_t   job;
		int unsigned pick;
		job = '0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// out-of-range jobs of every kind
			case ($urandom_range(0, 2))
				0: begin
					job.people = 8'd0;
					job.stride = 8'($urandom_range(0, 255));
				end
				1: begin
					job.people = 8'($urandom_range(MAX_PEOPLE + 1, 255));
					job.stride = 8'($urandom_range(0, 255));
				end
				default: begin
					job.people = 8'($urandom_range(1, MAX_PEOPLE));
					job.stride = 8'd0;
				end
			endcase
		end else if (pick < 20) begin
			// large steps on small rings keep the run time bounded
			job.people = 8'($urandom_range(1, 6));
			job.stride = 8'($urandom_range(13, 255));
		end else begin
			job.people = 8'($urandom_range(1, MAX_PEOPLE));
			job.stride = 8'($urandom_range(1, 12));
		end
		return job;
	endfunction

	task automatic drive_jobs();
		ring_job_t      job;
		survivor_beat_t beat;
		int unsigned    total;
		total = job_q.size();
		for (int idx = 0; idx < total; idx++) begin
			job = job_q[idx];
			if (idx >= total - QUIET_TAIL)
				idle_on = 1'b0;
			if (idle_on && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			in_valid <= 1'b1;
			people_count <= job.people;
			step <= job.stride;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			beat = predict_survivor(job.people, job.stride);
			if (job.typed) begin
				beat.survivor = job.typed_survivor;
				beat.input_error = job.typed_error;
			end
			survivor_q.push_back(beat);
		end
		in_valid <= 1'b0;
	endtask

	// output side: random stall bursts and the beat check
	always @(posedge clk) begin
		survivor_beat_t want;
		int unsigned    hold;
		if (arst_n && out_valid && !out_stall) begin
			if (survivor_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: unexpected beat survivor=%0d input_error=%0b",
						$realtime, survivor, input_error);
			end else begin
				want = survivor_q.pop_front();
				if (survivor !== want.survivor || input_error !== want.input_error) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: mismatch survivor exp=%0d act=%0d, input_error exp=%0b act=%0b",
							$realtime, want.survivor, survivor, want.input_error, input_error);
				end
			end
		end
		if (idle_on && hold == 0 && $urandom_range(0, 7) == 0)
			hold = $urandom_range(1, 19);
		if (hold > 0) begin
			out_stall <= 1'b1;
			hold--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		for (int i = 0; i < MAX_PEOPLE; i++)
			ring_alive[i] = 1'b1;
		ring_pos = 0;
		ring_counted = 0;
		ring_removed = 0;
		for (int i = 0; i < DIR_ROWS; i++)
			job_q.push_back(dir_table[i]);
		for (int i = 0; i < RANDOM_JOBS; i++)
			job_q.push_back(random_job());
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			begin
				drive_jobs();
				while (survivor_q.size() != 0)
					@(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			begin
				while (idle_cycles < WATCHDOG_LIMIT)
					@(posedge clk);
				timed_out = 1'b1;
			end
		join_any
		if (timed_out)
			$display("josephus_last_survivor_test: done, errors");
		else if (mismatch_count == 0)
			$display("josephus_last_survivor_test: done, clean");
		else
			$display("josephus_last_survivor_test: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/jls_pkg.sv
hw/rtl/jls_cell.sv
hw/rtl/jls_chain.sv
hw/rtl/josephus_last_survivor.sv
hw/rtl/jls_checker.sv
tb/sv/josephus_last_survivor_test.sv
